### hdl/tasd_pkg.sv
// ----------------------------------------------------------------------------
// tasd_pkg: shared types and constants
// Widths of the result fields, default sizes and the sorted-position codes
// used by the front classifier and the back arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tasd_pkg;

  // default edge length width
  localparam int LEN_BITS_DEF = 12;

  // result field widths
  localparam int AREA_W  = 53;
  localparam int DERIV_W = 43;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // sorted position taken by the first length
  typedef logic [1:0] pos_t;
  localparam pos_t POS_A = 2'd0;
  localparam pos_t POS_B = 2'd1;
  localparam pos_t POS_C = 2'd2;

endpackage

`default_nettype wire

### hdl/tasd_front.sv
// ----------------------------------------------------------------------------
// tasd_front: sort and classify
// Sorts the edge-length triple descending, tracks where the first length lands
// and forms the four stable Heron factors.
// ----------------------------------------------------------------------------
`default_nettype none

module tasd_front #(
  parameter int LEN_BITS = tasd_pkg::LEN_BITS_DEF
) (
  input  wire logic [LEN_BITS-1:0]   len_var,
  input  wire logic [LEN_BITS-1:0]   len_second,
  input  wire logic [LEN_BITS-1:0]   len_third,
  output logic [LEN_BITS+1:0]        fac_s,
  output logic signed [LEN_BITS:0]   fac_a,
  output logic [LEN_BITS-1:0]        fac_b,
  output logic [LEN_BITS:0]          fac_c,
  output tasd_pkg::pos_t             pos
);
  import tasd_pkg::*;

  logic [LEN_BITS-1:0] sa;
  logic [LEN_BITS-1:0] sb;
  logic [LEN_BITS-1:0] sc;

  // compare-swap network, position tracked only through real swaps
  always_comb begin
    logic [LEN_BITS-1:0] t;
    logic                in_a;
    logic                in_b;
    t    = '0;
    sa   = len_var;
    sb   = len_second;
    sc   = len_third;
    in_a = 1'b1;
    in_b = 1'b0;
    if (sa < sb) begin
      t    = sa;
      sa   = sb;
      sb   = t;
      in_a = 1'b0;
      in_b = 1'b1;
    end
    if (sa < sc) begin
      t    = sa;
      sa   = sc;
      sc   = t;
      in_a = 1'b0;
    end
    if (sb < sc) begin
      t    = sb;
      sb   = sc;
      sc   = t;
      in_b = !(in_a || in_b);
    end
    if (in_a) begin
      pos = POS_A;
    end else if (in_b) begin
      pos = POS_B;
    end else begin
      pos = POS_C;
    end
  end

  logic [LEN_BITS-1:0] diff_ab;

  // a >= b >= c, so a - b and c + (a - b) never go negative or past a
  assign diff_ab = sa - sb;

  assign fac_s = (LEN_BITS+2)'(sa) + (LEN_BITS+2)'(sb) + (LEN_BITS+2)'(sc);
  assign fac_a = $signed({1'b0, sc}) - $signed({1'b0, diff_ab});
  assign fac_b = sc + diff_ab;
  assign fac_c = (LEN_BITS+1)'(sa) + (LEN_BITS+1)'(sb) - (LEN_BITS+1)'(sc);

endmodule

`default_nettype wire

### hdl/tasd_fifo.sv
// ----------------------------------------------------------------------------
// tasd_fifo: item queue
// Short register queue that decouples the front classifier from the back
// arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tasd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tasd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic do_push;
  logic do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hdl/tasd_back.sv
// ----------------------------------------------------------------------------
// tasd_back: product pipeline
// Three-stage multiply-add pipeline: pair products, cross products, final
// sum into the output register. The whole pipe advances together.
// ----------------------------------------------------------------------------
`default_nettype none

module tasd_back #(
  parameter int LEN_BITS = tasd_pkg::LEN_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         item_avail,
  output logic                              item_take,
  input  wire logic [LEN_BITS+1:0]          fac_s,
  input  wire logic signed [LEN_BITS:0]     fac_a,
  input  wire logic [LEN_BITS-1:0]          fac_b,
  input  wire logic [LEN_BITS:0]            fac_c,
  input  wire tasd_pkg::pos_t               pos,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [tasd_pkg::AREA_W-1:0]  out_area_sq_x16,
  output logic signed [tasd_pkg::DERIV_W-1:0] out_darea_sq_x16
);
  import tasd_pkg::*;

  localparam int BC_W   = 2*LEN_BITS + 1;   // unsigned B*C
  localparam int SA_W   = 2*LEN_BITS + 4;   // signed S*A
  localparam int XY_W   = LEN_BITS + 3;     // signed factor sums
  localparam int AR_W   = 4*LEN_BITS + 6;   // signed area product
  localparam int DX_W   = 3*LEN_BITS + 5;   // signed BC*X
  localparam int DY_W   = 3*LEN_BITS + 7;   // signed SA*Y
  localparam int DS_W   = 3*LEN_BITS + 8;   // signed derivative sum

  logic pipe_en;

  // advance unless the output register holds an untaken result
  assign pipe_en   = !out_valid || out_ready;
  assign item_take = pipe_en && item_avail;

  // stage 1: pair products and position-dependent sums
  logic                   v1_r;
  logic [BC_W-1:0]        bc_r;
  logic signed [SA_W-1:0] sa_r;
  logic signed [XY_W-1:0] x_r, x_nxt;
  logic signed [XY_W-1:0] y_r, y_nxt;

  logic signed [XY_W-1:0] s_x;
  logic signed [XY_W-1:0] a_x;
  logic signed [XY_W-1:0] b_x;
  logic signed [XY_W-1:0] c_x;

  assign s_x = $signed({1'b0, fac_s});
  assign a_x = XY_W'(fac_a);
  assign b_x = $signed({3'b000, fac_b});
  assign c_x = $signed({2'b00, fac_c});

  // dA = BC*X + SA*Y, X and Y picked by the sorted position
  always_comb begin
    unique case (pos)
      POS_A: begin
        x_nxt = a_x - s_x;
        y_nxt = c_x + b_x;
      end
      POS_B: begin
        x_nxt = a_x + s_x;
        y_nxt = b_x - c_x;
      end
      default: begin
        x_nxt = a_x + s_x;
        y_nxt = c_x - b_x;
      end
    endcase
  end

  // stage 2: cross products
  logic                   v2_r;
  logic signed [AR_W-1:0] area_r;
  logic signed [DX_W-1:0] dx_r;
  logic signed [DY_W-1:0] dy_r;

  logic signed [BC_W:0]   bc_sx;
  assign bc_sx = $signed({1'b0, bc_r});

  // stage 3: output register
  logic                      v3_r;
  logic signed [AREA_W-1:0]  area_out_r;
  logic signed [DERIV_W-1:0] deriv_out_r;
  logic signed [DS_W-1:0]    deriv_sum;

  assign deriv_sum = DS_W'(dx_r) + DS_W'(dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= item_avail;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      bc_r        <= BC_W'(fac_b) * BC_W'(fac_c);
      sa_r        <= SA_W'($signed({1'b0, fac_s})) * SA_W'(fac_a);
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      area_r      <= AR_W'(bc_sx) * AR_W'(sa_r);
      dx_r        <= DX_W'(bc_sx) * DX_W'(x_r);
      dy_r        <= DY_W'(sa_r) * DY_W'(y_r);
      area_out_r  <= AREA_W'(area_r);
      deriv_out_r <= DERIV_W'(deriv_sum);
    end
  end

  assign out_valid        = v3_r;
  assign out_area_sq_x16  = area_out_r;
  assign out_darea_sq_x16 = deriv_out_r;

endmodule

`default_nettype wire

### hdl/triangle_area_squared_and_derivative_core.sv
// ----------------------------------------------------------------------------
// triangle_area_squared_and_derivative_core: stable Heron area engine
// Sixteen times the squared triangle area and its derivative against the
// first edge length, one transaction per cycle while out_ready stays high.
// ----------------------------------------------------------------------------
// Each input transaction carries three unsigned edge lengths. The front sorts
// them descending, notes which sorted slot the first length took and forms
// the stable Heron factors S, A, B, C; these enter a four-entry queue. The
// back pops one entry per cycle, while the pipe advances, into a three-stage
// multiply pipeline (pair products B*C and S*A, then the three cross
// products, then the final sum) whose last stage is the output register.
// The block sustains one transaction per cycle in and out while out_ready
// stays high; a result waits in the output register while out_ready is low.
// The queue absorbs output stalls, so in_ready drops only once four items are
// waiting. Area is the exact product S*A*B*C and goes negative for lengths
// that cannot form a triangle; nothing is clamped. The block keeps no state
// across items, so reset only empties the queue and the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_area_squared_and_derivative_core #(
  parameter int LEN_BITS    = tasd_pkg::LEN_BITS_DEF,
  parameter int QUEUE_DEPTH = tasd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [LEN_BITS-1:0]            in_len_var,
  input  wire logic [LEN_BITS-1:0]            in_len_second,
  input  wire logic [LEN_BITS-1:0]            in_len_third,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [tasd_pkg::AREA_W-1:0]  out_area_sq_x16,
  output logic signed [tasd_pkg::DERIV_W-1:0] out_darea_sq_x16
);
  import tasd_pkg::*;

  // queue entry: S, A, B, C and the sorted position
  localparam int S_W    = LEN_BITS + 2;
  localparam int A_W    = LEN_BITS + 1;
  localparam int B_W    = LEN_BITS;
  localparam int C_W    = LEN_BITS + 1;
  localparam int POS_W  = $bits(pos_t);
  localparam int ITEM_W = S_W + A_W + B_W + C_W + POS_W;

  // front side factors
  logic [S_W-1:0]        f_s;
  logic signed [A_W-1:0] f_a;
  logic [B_W-1:0]        f_b;
  logic [C_W-1:0]        f_c;
  pos_t                  f_pos;

  // back side factors
  logic [S_W-1:0]        q_s;
  logic [A_W-1:0]        q_a;
  logic [B_W-1:0]        q_b;
  logic [C_W-1:0]        q_c;
  pos_t                  q_pos;

  logic [ITEM_W-1:0] push_item;
  logic [ITEM_W-1:0] pop_item;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;

  // sort and classify the incoming transaction
  tasd_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .len_var    (in_len_var),
    .len_second (in_len_second),
    .len_third  (in_len_third),
    .fac_s      (f_s),
    .fac_a      (f_a),
    .fac_b      (f_b),
    .fac_c      (f_c),
    .pos        (f_pos)
  );

  // accept whenever the queue has room, regardless of output backpressure
  assign in_ready  = !q_full;
  assign push_item = {f_s, f_a, f_b, f_c, f_pos};

  tasd_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_item),
    .empty     (q_empty)
  );

  assign {q_s, q_a, q_b, q_c, q_pos} = pop_item;

  // multiply pipeline; pops an entry whenever the pipe advances
  tasd_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_avail       (!q_empty),
    .item_take        (q_pop),
    .fac_s            (q_s),
    .fac_a            ($signed(q_a)),
    .fac_b            (q_b),
    .fac_c            (q_c),
    .pos              (q_pos),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_area_sq_x16  (out_area_sq_x16),
    .out_darea_sq_x16 (out_darea_sq_x16)
  );

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for triangle_area_squared_and_derivative_core
// Drives edge-length triples through the valid/ready input and predicts the
// stable Heron area and derivative for each accepted transaction. Checks
// every result in order under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import tasd_pkg::*;

  localparam int LEN_W         = LEN_BITS_DEF;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int LONG_HOLD     = 400;   // receiver hold-off that fills the block
  localparam int HOLD_BURST    = 40;    // items offered while the receiver holds
  localparam int HOLD_AT       = 700;   // random item count that triggers the hold
  localparam int PAUSE_AT      = 1300;  // random item count that triggers a drain
  localparam int SETTLE_CYCLES = 10;    // idle time after the last drain
  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int MAX_REPORTS   = 10;

  // Hand-picked triples: field extremes, every sorted slot of the first
  // length, ties in each arrangement, degenerate and impossible triangles.
  localparam logic [3*LEN_W-1:0] DIRECTED_LENGTHS [24] = '{
    {12'd0,    12'd0,    12'd0},
    {12'd4095, 12'd4095, 12'd4095},
    {12'd4095, 12'd0,    12'd0},
    {12'd0,    12'd4095, 12'd0},
    {12'd0,    12'd0,    12'd4095},
    {12'd3,    12'd4,    12'd5},
    {12'd3,    12'd5,    12'd4},
    {12'd4,    12'd3,    12'd5},
    {12'd4,    12'd5,    12'd3},
    {12'd5,    12'd3,    12'd4},
    {12'd5,    12'd4,    12'd3},
    {12'd5,    12'd5,    12'd3},
    {12'd5,    12'd3,    12'd5},
    {12'd3,    12'd5,    12'd5},
    {12'd3,    12'd3,    12'd5},
    {12'd3,    12'd5,    12'd3},
    {12'd5,    12'd3,    12'd3},
    {12'd2,    12'd1,    12'd1},
    {12'd1,    12'd2,    12'd1},
    {12'd4095, 12'd1,    12'd1},
    {12'd4095, 12'd4095, 12'd1},
    {12'd2048, 12'd2047, 12'd4095},
    {12'd1365, 12'd2730, 12'd4095},
    {12'd2730, 12'd4095, 12'd1365}
  };

  // One predicted result, with the lengths kept for mismatch reports.
  typedef struct {
    logic [LEN_W-1:0]          len_var;
    logic [LEN_W-1:0]          len_second;
    logic [LEN_W-1:0]          len_third;
    pos_t                      slot;
    logic signed [AREA_W-1:0]  area;
    logic signed [DERIV_W-1:0] darea;
  } heron_expect_t;

  // Scoreboard: predicts each accepted transaction and checks results in order.
  class heron_scoreboard;
    heron_expect_t expected_areas[$];
    int mismatches     = 0;
    int noted          = 0;
    int checked        = 0;
    int negative_areas = 0;
    int tied_items     = 0;
    int slot_hits[3]   = '{0, 0, 0};

    // Sort descending (swap on strict less-than only), follow the first
    // length through the swaps, then form the four stable factors.
    function heron_expect_t predict_heron(logic [LEN_W-1:0] v, s, t);
      heron_expect_t res;
      longint big, mid, low, tmp;
      longint fs, fa, fb, fc;
      longint no_s, no_a, no_b, no_c, area, darea;
      res.len_var    = v;
      res.len_second = s;
      res.len_third  = t;
      big = longint'(v);
      mid = longint'(s);
      low = longint'(t);
      res.slot = POS_A;
      if (big < mid) begin
        tmp = big; big = mid; mid = tmp;
        res.slot = POS_B;
      end
      if (big < low) begin
        tmp = big; big = low; low = tmp;
        if (res.slot == POS_A) res.slot = POS_C;
      end
      if (mid < low) begin
        tmp = mid; mid = low; low = tmp;
        if (res.slot == POS_B) res.slot = POS_C;
        else if (res.slot == POS_C) res.slot = POS_B;
      end
      fs = big + (mid + low);
      fa = low - (big - mid);
      fb = low + (big - mid);
      fc = big + (mid - low);
      // products leaving out one factor each
      no_s = fa * fb * fc;
      no_a = fs * fb * fc;
      no_b = fs * fa * fc;
      no_c = fs * fa * fb;
      area = fs * fa * fb * fc;
      case (res.slot)
        POS_A:   darea = no_s - no_a + no_b + no_c;
        POS_B:   darea = no_s + no_a - no_b + no_c;
        default: darea = no_s + no_a + no_b - no_c;
      endcase
      res.area  = area[AREA_W-1:0];
      res.darea = darea[DERIV_W-1:0];
      return res;
    endfunction

    function void note_triangle(logic [LEN_W-1:0] v, s, t);
      heron_expect_t res;
      res = predict_heron(v, s, t);
      expected_areas.push_back(res);
      noted++;
      slot_hits[res.slot]++;
      if (res.area < 0) negative_areas++;
      if (v == s || s == t || v == t) tied_items++;
    endfunction

    function void check_result(logic signed [AREA_W-1:0] area,
                               logic signed [DERIV_W-1:0] darea);
      heron_expect_t want;
      if (expected_areas.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with nothing pending: area %0d darea %0d",
                   $time, area, darea);
        return;
      end
      want = expected_areas.pop_front();
      checked++;
      if (area !== want.area || darea !== want.darea) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] lengths %0d %0d %0d: area exp %0d got %0d, darea exp %0d got %0d",
                   $time, want.len_var, want.len_second, want.len_third,
                   want.area, area, want.darea, darea);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [LEN_W-1:0]          in_len_var;
  logic [LEN_W-1:0]          in_len_second;
  logic [LEN_W-1:0]          in_len_third;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [AREA_W-1:0]  out_area_sq_x16;
  logic signed [DERIV_W-1:0] out_darea_sq_x16;

  heron_scoreboard sb = new();

  // Bumped by the sender to ask the receiver for one long hold-off.
  int hold_requests = 0;

  triangle_area_squared_and_derivative_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_len_var       (in_len_var),
    .in_len_second    (in_len_second),
    .in_len_third     (in_len_third),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_area_sq_x16  (out_area_sq_x16),
    .out_darea_sq_x16 (out_darea_sq_x16)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor both channels at the edge. Values read here are the pre-edge
  // ones, so the check never depends on event order within the step.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_triangle(in_len_var, in_len_second, in_len_third);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_area_sq_x16, out_darea_sq_x16);
  end

  // Present one triple and hold it until the block takes it. Return at the
  // accepting edge without touching in_valid, so back-to-back items never
  // lower and raise valid in the same step.
  task automatic offer_lengths(input logic [LEN_W-1:0] v, s, t);
    in_valid      <= 1'b1;
    in_len_var    <= v;
    in_len_second <= s;
    in_len_third  <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_areas.size() != 0) @(posedge clk);
  endtask

  // Draw a triple from a mix of shapes: raw random, well-formed triangles,
  // ties, tiny lengths and edge values. Shuffle so any field takes any slot.
  function automatic void pick_lengths(output logic [LEN_W-1:0] v, s, t);
    int lens[3];
    int shape, lo, hi, k, tmp;
    shape = $urandom_range(0, 99);
    if (shape < 30) begin
      foreach (lens[i]) lens[i] = $urandom_range(0, 4095);
    end else if (shape < 65) begin
      lens[0] = $urandom_range(0, 4095);
      lens[1] = $urandom_range(0, 4095);
      lo = (lens[0] > lens[1]) ? lens[0] - lens[1] : lens[1] - lens[0];
      hi = (lens[0] + lens[1] > 4095) ? 4095 : lens[0] + lens[1];
      lens[2] = $urandom_range(lo, hi);
    end else if (shape < 80) begin
      lens[0] = $urandom_range(0, 4095);
      lens[1] = $urandom_range(0, 4095);
      case ($urandom_range(0, 2))
        0:       lens[2] = lens[0];
        1:       lens[2] = lens[1];
        default: begin
          lens[1] = lens[0];
          lens[2] = lens[0];
        end
      endcase
    end else if (shape < 90) begin
      foreach (lens[i]) lens[i] = $urandom_range(0, 7);
    end else begin
      foreach (lens[i]) begin
        case ($urandom_range(0, 5))
          0:       lens[i] = 0;
          1:       lens[i] = 1;
          2:       lens[i] = 2048;
          3:       lens[i] = 4094;
          4:       lens[i] = 4095;
          default: lens[i] = $urandom_range(0, 4095);
        endcase
      end
    end
    k = $urandom_range(0, 2);
    tmp = lens[0]; lens[0] = lens[k]; lens[k] = tmp;
    k = $urandom_range(1, 2);
    tmp = lens[1]; lens[1] = lens[k]; lens[k] = tmp;
    v = LEN_W'(lens[0]);
    s = LEN_W'(lens[1]);
    t = LEN_W'(lens[2]);
  endfunction

  // Receiver: stretches of steady accept, coin-flip stalls, light stalls and
  // a fixed duty pattern. Break off at once when a long hold-off is asked.
  initial begin : result_sink
    int mode, span, holds_done;
    holds_done = 0;
    forever begin
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      for (int n = 0; n < span; n++) begin
        if (hold_requests != holds_done) break;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          2:       out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ((n % 5) < 2);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [LEN_W-1:0] v, s, t;
    int sent, burst, gap;
    bit held, paused;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_len_var    <= '0;
    in_len_second <= '0;
    in_len_third  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed triples back to back, then let the pipeline empty.
    for (int i = 0; i < 24; i++)
      offer_lengths(DIRECTED_LENGTHS[i][3*LEN_W-1:2*LEN_W],
                    DIRECTED_LENGTHS[i][2*LEN_W-1:LEN_W],
                    DIRECTED_LENGTHS[i][LEN_W-1:0]);
    drain_results();

    // Random part in bursts with random gaps, some of them zero.
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        pick_lengths(v, s, t);
        offer_lengths(v, s, t);
        sent++;
      end
      // Hold the receiver off and keep offering so the queue fills and
      // in_ready drops.
      if (!held && sent >= HOLD_AT) begin
        held = 1'b1;
        hold_requests++;
        repeat (HOLD_BURST) begin
          pick_lengths(v, s, t);
          offer_lengths(v, s, t);
          sent++;
        end
      end
      // Pause mid-run until every outstanding result has come out.
      if (!paused && sent >= PAUSE_AT) begin
        paused = 1'b1;
        drain_results();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) idle_sender(gap);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d triangles (%0d impossible, %0d tied); first length to a/b/c %0d/%0d/%0d",
             sb.noted, sb.negative_areas, sb.tied_items,
             sb.slot_hits[POS_A], sb.slot_hits[POS_B], sb.slot_hits[POS_C]);
    $display("Checked %0d results, %0d mismatches, %0d still pending",
             sb.checked, sb.mismatches, sb.expected_areas.size());
    if (sb.mismatches == 0 && sb.expected_areas.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
